// ===== rtl/core/bpdc_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button press duration classifier - shared types and constants
// Event codes, register indexes and the structs passed between the units.
// -----------------------------------------------------------------------------
package bpdc_pkg;

   localparam int DUR_W       = 16;
   localparam int STEP_W      = 10;
   localparam int KIND_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Event codes carried on the result channel
   localparam logic [KIND_W-1:0] EV_PRESSED      = 3'd0;
   localparam logic [KIND_W-1:0] EV_SHORT        = 3'd1;
   localparam logic [KIND_W-1:0] EV_MEDIUM       = 3'd2;
   localparam logic [KIND_W-1:0] EV_LONG         = 3'd3;
   localparam logic [KIND_W-1:0] EV_LONG_LONG    = 3'd4;
   localparam logic [KIND_W-1:0] EV_UNCLASSIFIED = 3'd5;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PULL_UP         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_LOW      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LIMIT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LONG_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_STEP       = 3'd5;

   // Reset values of the registers
   localparam logic              RST_PULL_UP         = 1'b1;
   localparam logic [DUR_W-1:0]  RST_SHORT_LIMIT     = 16'd250;
   localparam logic [DUR_W-1:0]  RST_MEDIUM_LOW      = 16'd5000;
   localparam logic [DUR_W-1:0]  RST_LONG_LIMIT      = 16'd10000;
   localparam logic [DUR_W-1:0]  RST_LONG_LONG_LIMIT = 16'd15000;
   localparam logic [STEP_W-1:0] RST_TICK_STEP       = 10'd50;

   localparam logic [DUR_W-1:0]  DUR_MAX = 16'hFFFF;

   typedef struct packed {
      logic              pull_up;
      logic [DUR_W-1:0]  short_limit;
      logic [DUR_W-1:0]  medium_low;
      logic [DUR_W-1:0]  long_limit;
      logic [DUR_W-1:0]  long_long_limit;
      logic [STEP_W-1:0] tick_step;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [DUR_W-1:0]  press_duration;
   } result_type;

endpackage

// ===== rtl/core/bpdc_csr.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button press duration classifier - configuration registers
// Holds the pull-up setting, the class thresholds and the tick step.
// -----------------------------------------------------------------------------
module bpdc_csr
   import bpdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PULL_UP:         cfg_in.pull_up         = csr_data[0];
            CSR_SHORT_LIMIT:     cfg_in.short_limit     = csr_data[DUR_W-1:0];
            CSR_MEDIUM_LOW:      cfg_in.medium_low      = csr_data[DUR_W-1:0];
            CSR_LONG_LIMIT:      cfg_in.long_limit      = csr_data[DUR_W-1:0];
            CSR_LONG_LONG_LIMIT: cfg_in.long_long_limit = csr_data[DUR_W-1:0];
            CSR_TICK_STEP:       cfg_in.tick_step       = csr_data[STEP_W-1:0];
            default:             cfg_in = cfg_ff;   // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pull_up         <= RST_PULL_UP;
         cfg_ff.short_limit     <= RST_SHORT_LIMIT;
         cfg_ff.medium_low      <= RST_MEDIUM_LOW;
         cfg_ff.long_limit      <= RST_LONG_LIMIT;
         cfg_ff.long_long_limit <= RST_LONG_LONG_LIMIT;
         cfg_ff.tick_step       <= RST_TICK_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/bpdc_engine.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button press duration classifier - press tracking engine
// Edge expectation, press timing and release classification, one item a cycle on item_fire.
// -----------------------------------------------------------------------------
module bpdc_engine
   import bpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_fire,
   input  logic       item_mode,
   input  logic       item_level,
   output logic       res_valid,
   output result_type res
);

   logic             awaiting_ff, awaiting_in;
   logic             pressing_ff, pressing_in;
   logic [DUR_W-1:0] duration_ff, duration_in;
   logic             pressed_level;
   logic [DUR_W:0]   sum;

   function automatic logic [KIND_W-1:0] classify(input logic [DUR_W-1:0] d,
                                                  input cfg_type c);
      logic [KIND_W-1:0] k;
      if (d <= c.short_limit)
         k = EV_SHORT;
      else if (d >= c.medium_low && d <= c.long_limit)
         k = EV_MEDIUM;
      else if (d > c.long_limit && d <= c.long_long_limit)
         k = EV_LONG;
      else if (d > c.long_long_limit)
         k = EV_LONG_LONG;
      else
         k = EV_UNCLASSIFIED;
      return k;
   endfunction

   assign pressed_level = ~cfg.pull_up;
   assign sum = {1'b0, duration_ff} + {{(DUR_W + 1 - STEP_W){1'b0}}, cfg.tick_step};

   always_comb begin
      awaiting_in = awaiting_ff;
      pressing_in = pressing_ff;
      duration_in = duration_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (item_fire) begin
         if (item_mode) begin
            // tick: while pressing and below the long-long limit, advance the duration, saturating
            if (pressing_ff && duration_ff < cfg.long_long_limit) begin
               duration_in = sum[DUR_W] ? DUR_MAX : sum[DUR_W-1:0];
            end
         end else if (awaiting_ff) begin
            if (item_level == pressed_level) begin
               awaiting_in        = 1'b0;
               pressing_in        = 1'b1;
               duration_in        = '0;
               res_valid          = 1'b1;
               res.event_kind     = EV_PRESSED;
               res.press_duration = '0;
            end
         end else if (item_level != pressed_level) begin
            awaiting_in = 1'b1;
            if (pressing_ff) begin
               res_valid          = 1'b1;
               res.event_kind     = classify(duration_ff, cfg);
               res.press_duration = duration_ff;
               pressing_in        = 1'b0;
               duration_in        = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         pressing_ff <= 1'b0;
         duration_ff <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         pressing_ff <= pressing_in;
         duration_ff <= duration_in;
      end
   end

   // A press is timed exactly while the release edge is expected
   a_state_pair: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff != pressing_ff)
      else $error("press timing and edge expectation disagree");

   // No time accumulates outside a press
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !pressing_ff |-> duration_ff == '0)
      else $error("duration non-zero while not pressing");

   // Duration only grows during a press
   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      pressing_ff && pressing_in |=> duration_ff >= $past(duration_ff))
      else $error("duration fell during a press");

endmodule

// ===== rtl/core/button_press_duration_classifier_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Button press duration classifier
// Tracks button edges and timer ticks and reports press and release events.
// -----------------------------------------------------------------------------
// Usage
//   req channel: one transfer per pin-change event or timer tick. tuser holds
//     the mode (0 pin event, 1 tick), tdata bit 0 the sampled pin level.
//   rsp channel: one transfer per pressed or release event. tuser holds the
//     event kind, tdata the press duration in milliseconds.
//   csr channel: register writes by index; always ready. Write only while the
//     block is idle.
// Path: a request is held in the input register, then its result in the result
//   register until the rsp transfer completes.
// Throughput: one request per cycle sustained while rsp_tready is high; the input
//   register and the result register are separate stages, so a new request is taken
//   while a result waits on the rsp side, if the input register is free.
// Reset: edge expectation returns to press, timing stops, the duration clears
//   and the configuration registers take their default values.
// Stall: when rsp_tready is low with a result held, the input register still
//   takes one request; req_tready drops only when both stages are full.
// -----------------------------------------------------------------------------
module button_press_duration_classifier_unit
   import bpdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] pin_level, [7:1] zero
   input  logic                   req_tuser,   // [0] mode
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DUR_W-1:0]       rsp_tdata,   // [15:0] press_duration
   output logic [KIND_W-1:0]      rsp_tuser,   // [2:0] event_kind
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff;
   logic       in_level_ff;
   logic       advance;
   logic       req_fire;
   logic       eng_valid;
   result_type eng_res;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   // configuration writes always complete; csr_ready is tied high
   assign csr_ready = 1'b1;

   bpdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // move the held request into the engine when the result slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff  <= req_tuser;
         in_level_ff <= req_tdata[0];
      end
   end

   bpdc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_fire  (advance),
      .item_mode  (in_mode_ff),
      .item_level (in_level_ff),
      .res_valid  (eng_valid),
      .res        (eng_res)
   );

   // result register: load on advance, drop once the transfer completes
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = eng_valid;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && eng_valid) begin
         out_res_ff <= eng_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.press_duration;
   assign rsp_tuser  = out_res_ff.event_kind;

   // A pressed event always reports zero duration
   a_pressed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_PRESSED |-> rsp_tdata == '0)
      else $error("pressed event with non-zero duration");

   // Backpressure reaches the request side only with both stages full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request stalled with a free stage");

endmodule
